[hdl/alr_pkg.sv]
// alr_pkg: shared widths, defaults, register indexes and control/status structs
// for the antialiased line rasterizer; used by all hdl modules
`default_nettype none

package alr_pkg;

  localparam int COORD_W      = 20;
  localparam int PIX_W        = 12;
  localparam int COV1_W       = 9;
  localparam int COV_W        = 8;
  localparam int COLOR_W      = 8;
  localparam int SLOPE_FRAC   = 16;
  localparam int QUOT_W       = SLOPE_FRAC + 1;
  localparam int GRAD_W       = SLOPE_FRAC + 2;
  localparam int ACC_W        = 32;
  localparam int CNT_W        = 7;
  localparam int DIV_CNT_W    = 5;
  localparam int REG_IDX_W    = 2;
  localparam int IN_DATA_W    = 4 * COORD_W;
  localparam int OUT_FIELDS_W = 2 * PIX_W + 1 + COV1_W + COV_W + 3 * COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int DEF_MAX_SPAN      = 63;
  localparam int DEF_FRACTION_BITS = 8;

  localparam logic [COLOR_W-1:0]   COLOR_RESET = 8'hFF;
  localparam logic [REG_IDX_W-1:0] REG_RED     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GREEN   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLUE    = 2'd2;

  typedef struct packed {
    logic capture;
    logic sort;
    logic delta;
    logic div_step;
    logic slope;
    logic prod1;
    logic prod2;
    logic endm2;
    logic emit_a;
    logic emit_b;
    logic emit_i;
    logic emit_err;
  } alr_cmd_t;

  typedef struct packed {
    logic too_long;
    logic div_last;
    logic last_b;
    logic last_i;
    logic out_free;
  } alr_status_t;

endpackage

`default_nettype wire

[hdl/alr_ctrl.sv]
// alr_ctrl: sequencing state machine of the line rasterizer
// depends on alr_pkg; drives alr_dpath through alr_cmd_t / alr_status_t
`default_nettype none

module alr_ctrl import alr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire alr_status_t status,
  output alr_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SORT   = 4'd1;
  localparam logic [3:0] S_DELTA  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_SLOPE  = 4'd4;
  localparam logic [3:0] S_PROD1  = 4'd5;
  localparam logic [3:0] S_PROD2  = 4'd6;
  localparam logic [3:0] S_ENDM2  = 4'd7;
  localparam logic [3:0] S_EMIT_A = 4'd8;
  localparam logic [3:0] S_EMIT_B = 4'd9;
  localparam logic [3:0] S_EMIT_I = 4'd10;
  localparam logic [3:0] S_ERR    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SORT;
        end
      end
      S_SORT: begin
        cmd.sort   = 1'b1;
        state_next = S_DELTA;
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.too_long) begin
          state_next = S_ERR;
        end else begin
          cmd.div_step = 1'b1;
          if (status.div_last) begin
            state_next = S_SLOPE;
          end
        end
      end
      S_SLOPE: begin
        cmd.slope  = 1'b1;
        state_next = S_PROD1;
      end
      S_PROD1: begin
        cmd.prod1  = 1'b1;
        state_next = S_PROD2;
      end
      S_PROD2: begin
        cmd.prod2  = 1'b1;
        state_next = S_ENDM2;
      end
      S_ENDM2: begin
        cmd.endm2  = 1'b1;
        state_next = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (status.out_free) begin
          cmd.emit_a = 1'b1;
          state_next = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (status.out_free) begin
          cmd.emit_b = 1'b1;
          state_next = status.last_b ? S_IDLE : S_EMIT_I;
        end
      end
      S_EMIT_I: begin
        if (status.out_free) begin
          cmd.emit_i = 1'b1;
          if (status.last_i) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (status.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/alr_dpath.sv]
// alr_dpath: endpoint sort, bit-serial slope divider, endpoint multiplier,
// minor accumulator, color registers and output register; depends on alr_pkg
`default_nettype none

module alr_dpath import alr_pkg::*; #(
  parameter int MAX_SPAN      = DEF_MAX_SPAN,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [IN_DATA_W-1:0] in_data,
  input  wire logic                 cfg_valid,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data,
  input  wire alr_cmd_t             cmd,
  output alr_status_t               status,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [OUT_DATA_W-1:0]     out_data,
  output logic                      out_user,
  output logic                      out_last
);

  localparam int IPW   = COORD_W + 1 - FRACTION_BITS;
  localparam int DW    = FRACTION_BITS + 2;
  localparam int PW    = GRAD_W + DW;
  localparam int REM_W = COORD_W + 1;
  localparam int HALF  = 1 << (FRACTION_BITS - 1);
  localparam logic signed [IPW:0] SPAN_LIM = (IPW + 1)'(MAX_SPAN);
  localparam logic signed [IPW:0] SPAN_ONE = (IPW + 1)'(1);

  // color registers
  logic [COLOR_W-1:0] red, green, blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      red   <= COLOR_RESET;
      green <= COLOR_RESET;
      blue  <= COLOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RED:   red   <= cfg_data;
        REG_GREEN: green <= cfg_data;
        REG_BLUE:  blue  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // captured endpoints
  logic signed [COORD_W-1:0] sx, sy, ex, ey;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx <= in_data[COORD_W-1:0];
      sy <= in_data[2*COORD_W-1:COORD_W];
      ex <= in_data[3*COORD_W-1:2*COORD_W];
      ey <= in_data[4*COORD_W-1:3*COORD_W];
    end
  end

  // major axis pick and ordering
  logic signed [COORD_W:0]   xd, yd;
  logic [COORD_W:0]          axd, ayd;
  logic                      steep_c, swap_c;
  logic signed [COORD_W-1:0] a1_c, n1_c, a2_c, n2_c;
  logic signed [COORD_W-1:0] ma1, mi1, ma2, mi2;
  logic                      steep;

  always_comb begin
    xd      = (COORD_W + 1)'(ex) - (COORD_W + 1)'(sx);
    yd      = (COORD_W + 1)'(ey) - (COORD_W + 1)'(sy);
    axd     = xd[COORD_W] ? -xd : xd;
    ayd     = yd[COORD_W] ? -yd : yd;
    steep_c = !(axd > ayd);
    a1_c    = steep_c ? sy : sx;
    n1_c    = steep_c ? sx : sy;
    a2_c    = steep_c ? ey : ex;
    n2_c    = steep_c ? ex : ey;
    swap_c  = a1_c > a2_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.sort) begin
      steep <= steep_c;
      ma1   <= swap_c ? a2_c : a1_c;
      mi1   <= swap_c ? n2_c : n1_c;
      ma2   <= swap_c ? a1_c : a2_c;
      mi2   <= swap_c ? n1_c : n2_c;
    end
  end

  // deltas, rounded endpoint pixels, span
  logic signed [COORD_W:0]     majd_s, mind_s, r1, r2;
  logic [COORD_W-1:0]          amind_c;
  logic signed [IPW-1:0]       ip1_c, ip2_c;
  logic signed [IPW:0]         span_c;
  logic signed [DW-1:0]        d1_c, d2_c;
  logic signed [ACC_W-1:0]     ip1_ext, ip2_ext;

  always_comb begin
    majd_s  = (COORD_W + 1)'(ma2) - (COORD_W + 1)'(ma1);
    mind_s  = (COORD_W + 1)'(mi2) - (COORD_W + 1)'(mi1);
    amind_c = mind_s[COORD_W] ? COORD_W'(-mind_s) : mind_s[COORD_W-1:0];
    r1      = (COORD_W + 1)'(ma1) + (COORD_W + 1)'(HALF);
    r2      = (COORD_W + 1)'(ma2) + (COORD_W + 1)'(HALF);
    ip1_c   = r1[COORD_W:FRACTION_BITS];
    ip2_c   = r2[COORD_W:FRACTION_BITS];
    span_c  = (IPW + 1)'(ip2_c) - (IPW + 1)'(ip1_c);
    d1_c    = DW'(HALF) - DW'(r1[FRACTION_BITS-1:0]);
    d2_c    = DW'(HALF) - DW'(r2[FRACTION_BITS-1:0]);
    ip1_ext = ACC_W'(ip1_c);
    ip2_ext = ACC_W'(ip2_c);
  end

  logic [COORD_W-1:0]    majd;
  logic                  mneg, zero_len, abit;
  logic signed [DW-1:0]  d1, d2;
  logic [PIX_W-1:0]      major, pix2;
  logic                  too_long, last_b;
  logic [CNT_W-1:0]      steps;
  logic [REM_W-1:0]      rem;
  logic [QUOT_W-1:0]     quot;
  logic [DIV_CNT_W-1:0]  div_cnt;

  // one quotient bit per step
  logic              shin;
  logic [REM_W:0]    cand, diff;

  always_comb begin
    shin = (div_cnt == '0) ? abit : 1'b0;
    cand = {rem, shin};
    diff = cand - (REM_W + 1)'(majd);
  end

  // slope, products, minor accumulator
  logic signed [GRAD_W-1:0] grad;
  logic signed [PW-1:0]     prod;
  logic [ACC_W-1:0]         acc, m2;

  function automatic logic [ACC_W-1:0] endpoint_minor(
    input logic signed [COORD_W-1:0] mi,
    input logic signed [PW-1:0]      p
  );
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] corr;
    base = ACC_W'(mi) <<< (SLOPE_FRAC - FRACTION_BITS);
    corr = ACC_W'(p >>> FRACTION_BITS);
    return base + corr;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      majd     <= majd_s[COORD_W-1:0];
      mneg     <= mind_s[COORD_W];
      zero_len <= (majd_s == '0);
      abit     <= amind_c[0];
      rem      <= REM_W'(amind_c >> 1);
      quot     <= '0;
      div_cnt  <= '0;
      d1       <= d1_c;
      d2       <= d2_c;
      major    <= ip1_ext[PIX_W-1:0];
      pix2     <= ip2_ext[PIX_W-1:0];
      too_long <= span_c > SPAN_LIM;
      last_b   <= span_c <= SPAN_ONE;
      steps    <= CNT_W'(span_c) - CNT_W'(1);
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (!diff[REM_W]) begin
        rem  <= diff[REM_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= cand[REM_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
    if (cmd.slope) begin
      if (zero_len) begin
        grad <= '0;
      end else if (mneg) begin
        grad <= -GRAD_W'(quot);
      end else begin
        grad <= GRAD_W'(quot);
      end
    end
    if (cmd.prod1) begin
      prod <= grad * d1;
    end
    if (cmd.prod2) begin
      acc  <= endpoint_minor(mi1, prod);
      prod <= grad * d2;
    end
    if (cmd.endm2) begin
      m2 <= endpoint_minor(mi2, prod);
    end
    if (cmd.emit_a || cmd.emit_i) begin
      acc   <= acc + ACC_W'(grad);
      major <= major + PIX_W'(1);
    end
    if (cmd.emit_i) begin
      steps <= steps - CNT_W'(1);
    end
  end

  // result assembly
  logic [ACC_W-1:0]  sel_minor16;
  logic [PIX_W-1:0]  sel_major, sel_minor, px, py;
  logic [COV_W-1:0]  cov2;
  logic [COV1_W-1:0] cov1;
  logic              load, res_last;

  always_comb begin
    sel_minor16 = cmd.emit_b ? m2 : acc;
    sel_major   = cmd.emit_b ? pix2 : major;
    sel_minor   = sel_minor16[SLOPE_FRAC+PIX_W-1:SLOPE_FRAC];
    cov2        = sel_minor16[SLOPE_FRAC-1:SLOPE_FRAC-COV_W];
    cov1        = COV1_W'(1 << COV_W) - COV1_W'(cov2);
    px          = steep ? sel_minor : sel_major;
    py          = steep ? sel_major : sel_minor;
    load        = cmd.emit_a || cmd.emit_b || cmd.emit_i || cmd.emit_err;
    res_last    = (cmd.emit_b && last_b) || (cmd.emit_i && steps == CNT_W'(1))
                  || cmd.emit_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_last <= res_last;
      out_user <= cmd.emit_err;
      if (cmd.emit_err) begin
        out_data <= '0;
      end else begin
        out_data <= OUT_DATA_W'({blue, green, red, cov2, cov1, steep, py, px});
      end
    end
  end

  always_comb begin
    status.too_long = too_long;
    status.div_last = (div_cnt == DIV_CNT_W'(QUOT_W - 1));
    status.last_b   = last_b;
    status.last_i   = (steps == CNT_W'(1));
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

[hdl/antialiased_line_rasterizer_unit.sv]
// antialiased_line_rasterizer_unit: top level joining alr_ctrl and alr_dpath
// depends on alr_pkg, alr_ctrl, alr_dpath
//
// Takes one line segment per transfer on s_axis and streams its pixel pairs
// on m_axis. Endpoints are signed fixed point with FRACTION_BITS fraction bits.
// Each segment gives the first endpoint pair, the second endpoint pair, then
// one pair per major column or row in between; tlast marks the final pair.
// A segment whose rounded span exceeds MAX_SPAN gives a single transfer with
// tuser = 1, tlast = 1 and all-zero tdata.
// The cfg channel writes the color registers (index 0 red, 1 green, 2 blue);
// it is ready outside reset, other indexes are ignored, writes belong to idle time
// (the block itself does not enforce this). After a segment is taken the sequencer
// sorts it, forms the deltas, runs the bit-serial slope divider (one quotient bit
// per cycle), forms the slope and the endpoint products and minors, then registers
// the first pair. Further pairs follow one per cycle while m_axis is ready; a
// too-long segment skips the divider. s_axis_tready is high only between segments.
// A stalled m_axis holds the output register and the sequencer waits.
// Reset clears the sequencer and output valid and sets all colors to 255.
`default_nettype none

module antialiased_line_rasterizer_unit import alr_pkg::*; #(
  parameter int MAX_SPAN      = DEF_MAX_SPAN,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // pixel_x, pixel_y, second_along_x, coverage_first, coverage_second,
  // out_red, out_green, out_blue, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // too_long
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [COLOR_W-1:0]    cfg_data
);

  alr_cmd_t    cmd;
  alr_status_t status;

  assign cfg_ready = !rst;

  alr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  alr_dpath #(
    .MAX_SPAN      (MAX_SPAN),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
